FILE: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, command and status codes, word types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // Data format and iteration counts.
  localparam int DATA_WIDTH       = 16;
  localparam int FRAC_BITS        = 8;
  localparam int ANGLE_ITERATIONS = 14;
  localparam int CORDIC_GUARD     = 16;
  localparam int ATAN_LEN         = 24;

  // Internal widths.
  localparam int PW     = 2 * DATA_WIDTH;            // product
  localparam int SW     = PW + 2;                    // saturation input
  localparam int NW     = PW + 1;                    // divide numerator / sum of squares
  localparam int QW     = DATA_WIDTH + 2;            // quotient magnitude bits
  localparam int QB     = $clog2(QW);
  localparam int DW     = NW;                        // doubled divisor
  localparam int RW     = DW + QW;                   // divide remainder
  localparam int CW     = DATA_WIDTH + CORDIC_GUARD + 4;
  localparam int ZW     = 32;
  localparam int NSTEP  = (ANGLE_ITERATIONS > QW) ? ANGLE_ITERATIONS : QW;
  localparam int STEP_W = $clog2(NSTEP);

  // Command codes.
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_MAG = 3'd4;
  localparam logic [2:0] CMD_ARG = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // Rounding and angle constants.
  localparam logic signed [SW-1:0] RND_HALF  = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI    = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO    = -SAT_HI - SW'(1);
  localparam logic signed [ZW-1:0] Z_QUARTER = 32'sd5898240;
  localparam logic signed [ZW-1:0] ARG_RND   = 32'sd256;
  localparam int                   ARG_SHIFT = 9;
  localparam logic signed [ZW-1:0] HALF_TURN = 32'sd23040;

  // atan(2^-i) in units of 2^-16 degree.
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
    32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
    32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  // Operand word as taken from the input channel.
  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } in_t;

  // Products, sums and the pre-rotated vector.
  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [PW-1:0]         p_rr;
    logic signed [PW-1:0]         p_ii;
    logic signed [PW-1:0]         p_ri;
    logic signed [PW-1:0]         p_ir;
    logic [PW-1:0]                d_rr;
    logic [PW-1:0]                d_ii;
    logic signed [DATA_WIDTH:0]   as_re;
    logic signed [DATA_WIDTH:0]   as_im;
    logic signed [DATA_WIDTH:0]   x0;
    logic signed [DATA_WIDTH:0]   y0;
    logic signed [ZW-1:0]         z0;
    logic                         az;
  } prod_t;

  // Word carried down the divide / CORDIC step chain.
  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic [1:0]                   st;
    logic                         neg_re;
    logic                         neg_im;
    logic [RW-1:0]                rem_re;
    logic [RW-1:0]                rem_im;
    logic [DW-1:0]                den;
    logic [QW-1:0]                q_re;
    logic [QW-1:0]                q_im;
    logic signed [CW-1:0]         cx;
    logic signed [CW-1:0]         cy;
    logic signed [ZW-1:0]         cz;
    logic                         az;
  } pipe_t;

  typedef struct packed {
    logic                         flag;
    logic signed [DATA_WIDTH-1:0] val;
  } sat_t;

  // Clamp a wide signed value to the data range and flag the clamp.
  function automatic sat_t sat_w(input logic signed [SW-1:0] v);
    sat_t r;
    r.flag = 1'b0;
    r.val  = v[DATA_WIDTH-1:0];
    if (v > SAT_HI) begin
      r.flag = 1'b1;
      r.val  = SAT_HI[DATA_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r.flag = 1'b1;
      r.val  = SAT_LO[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined Q8.8 complex add, subtract, multiply, divide, squared magnitude
// and argument.
// ----------------------------------------------------------------------------
// Usage: each input word carries a command and two complex operands; each
// accepted word yields exactly one result word, in order. Both channels use
// valid/ready. The block accepts one word per clock cycle while in_ready is
// high. A result passes one operand register, one multiply stage, one
// combine stage, 18 step stages that each hold one divide quotient bit (the
// first ANGLE_ITERATIONS also one CORDIC iteration) and the output register.
// The step chain depth is the larger of the quotient width and iterations.
// The output register is backed by a one-word skid register, so the input
// side keeps accepting while one result waits. When the receiver stalls long
// enough for the skid register to fill, the whole pipeline holds and
// in_ready drops; no word is lost or repeated. Reset clears all valid bits;
// in_ready is high the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_cmd,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                           out_status
);
  import cau_pkg::*;

  logic                         adv;
  in_t                          s0_nxt;
  in_t                          s0_r;
  logic                         v0_r;
  prod_t                        s1_nxt;
  prod_t                        s1_r;
  logic                         v1_r;
  pipe_t                        s2_nxt;
  pipe_t                        s2_r;
  logic                         v2_r;
  pipe_t                        stp_nxt [NSTEP];
  pipe_t                        stp_r   [NSTEP];
  logic [NSTEP-1:0]             sv_r;
  logic signed [DATA_WIDTH-1:0] fin_re_nxt;
  logic signed [DATA_WIDTH-1:0] fin_im_nxt;
  logic [1:0]                   fin_st_nxt;
  logic                         fin_v;
  logic signed [DATA_WIDTH-1:0] out_re_r;
  logic signed [DATA_WIDTH-1:0] out_im_r;
  logic [1:0]                   out_st_r;
  logic                         out_v_r;
  logic signed [DATA_WIDTH-1:0] skid_re_r;
  logic signed [DATA_WIDTH-1:0] skid_im_r;
  logic [1:0]                   skid_st_r;
  logic                         skid_v_r;

  // The pipeline moves whenever the skid register is empty; no word is
  // taken while reset is held.
  assign adv      = !skid_v_r;
  assign in_ready = adv && rst_n;

  // Operand word from the input ports.
  always_comb begin
    s0_nxt.cmd  = in_cmd;
    s0_nxt.a_re = in_a_re;
    s0_nxt.a_im = in_a_im;
    s0_nxt.b_re = in_b_re;
    s0_nxt.b_im = in_b_im;
  end

  // Stage logic.
  cau_mult u_mult (.op(s0_r), .pr(s1_nxt));
  cau_init u_init (.pr(s1_r), .pp(s2_nxt));

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    if (g == 0) begin : g_first
      cau_step u_step (.pi(s2_r), .idx(STEP_W'(g)), .po(stp_nxt[g]));
    end else begin : g_rest
      cau_step u_step (.pi(stp_r[g-1]), .idx(STEP_W'(g)), .po(stp_nxt[g]));
    end
  end

  cau_final u_final (
    .pi     (stp_r[NSTEP-1]),
    .res_re (fin_re_nxt),
    .res_im (fin_im_nxt),
    .status (fin_st_nxt)
  );

  assign fin_v = sv_r[NSTEP-1];

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      sv_r <= '0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      sv_r <= {sv_r[NSTEP-2:0], v2_r};
    end
  end

  // Pipeline data registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      for (int i = 0; i < NSTEP; i++) begin
        stp_r[i] <= stp_nxt[i];
      end
    end
  end

  // Output register with skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_re_r <= skid_re_r;
        out_im_r <= skid_im_r;
        out_st_r <= skid_st_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_re_r <= fin_re_nxt;
        out_im_r <= fin_im_nxt;
        out_st_r <= fin_st_nxt;
        out_v_r  <= fin_v;
      end
    end else if (fin_v && adv) begin
      skid_re_r <= fin_re_nxt;
      skid_im_r <= fin_im_nxt;
      skid_st_r <= fin_st_nxt;
      skid_v_r  <= 1'b1;
    end
  end

  assign out_valid  = out_v_r;
  assign out_res_re = out_re_r;
  assign out_res_im = out_im_r;
  assign out_status = out_st_r;

  // The skid register only holds a word behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word present with empty output register");

  // A held skid word stays put while the receiver stalls.
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_v_r && !out_ready |=> skid_v_r && out_v_r && $stable(skid_re_r))
    else $error("skid word lost during stall");

  // Division by zero reports zero results.
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DIVZ) |-> (out_res_re == '0) && (out_res_im == '0))
    else $error("division by zero with nonzero result");

endmodule

`default_nettype wire

FILE: hdl/cau_mult.sv
// ----------------------------------------------------------------------------
// Multiply stage
// Forms all operand products, the sum or difference, and the quarter-turn
// pre-rotation of the first operand for the angle path.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_mult (
  input  cau_pkg::in_t   op,
  output cau_pkg::prod_t pr
);
  import cau_pkg::*;

  logic signed [DATA_WIDTH-1:0] m_re;
  logic signed [DATA_WIDTH-1:0] m_im;

  always_comb begin
    // Squared magnitude reuses the product lanes with a in place of b.
    m_re = (op.cmd == CMD_MAG) ? op.a_re : op.b_re;
    m_im = (op.cmd == CMD_MAG) ? op.a_im : op.b_im;

    pr.cmd  = op.cmd;
    pr.p_rr = PW'(op.a_re) * PW'(m_re);
    pr.p_ii = PW'(op.a_im) * PW'(m_im);
    pr.p_ri = PW'(op.a_re) * PW'(m_im);
    pr.p_ir = PW'(op.a_im) * PW'(m_re);
    pr.d_rr = PW'(op.b_re) * PW'(op.b_re);
    pr.d_ii = PW'(op.b_im) * PW'(op.b_im);

    // Sum or difference at one extra bit.
    if (op.cmd == CMD_SUB) begin
      pr.as_re = (DATA_WIDTH + 1)'(op.a_re) - (DATA_WIDTH + 1)'(op.b_re);
      pr.as_im = (DATA_WIDTH + 1)'(op.a_im) - (DATA_WIDTH + 1)'(op.b_im);
    end else begin
      pr.as_re = (DATA_WIDTH + 1)'(op.a_re) + (DATA_WIDTH + 1)'(op.b_re);
      pr.as_im = (DATA_WIDTH + 1)'(op.a_im) + (DATA_WIDTH + 1)'(op.b_im);
    end

    // Bring a into the right half plane.
    pr.x0 = (DATA_WIDTH + 1)'(op.a_re);
    pr.y0 = (DATA_WIDTH + 1)'(op.a_im);
    pr.z0 = '0;
    if (op.a_re < 0) begin
      if (op.a_im >= 0) begin
        pr.x0 = (DATA_WIDTH + 1)'(op.a_im);
        pr.y0 = -((DATA_WIDTH + 1)'(op.a_re));
        pr.z0 = Z_QUARTER;
      end else begin
        pr.x0 = -((DATA_WIDTH + 1)'(op.a_im));
        pr.y0 = (DATA_WIDTH + 1)'(op.a_re);
        pr.z0 = -Z_QUARTER;
      end
    end
    pr.az = (op.a_re == 0) && (op.a_im == 0);
  end

endmodule

`default_nettype wire

FILE: hdl/cau_init.sv
// ----------------------------------------------------------------------------
// Combine stage
// Rounds and saturates the finished operations and sets up the divider and
// CORDIC registers for the step chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_init (
  input  cau_pkg::prod_t pr,
  output cau_pkg::pipe_t pp
);
  import cau_pkg::*;

  sat_t                 s_re;
  sat_t                 s_im;
  logic [NW-1:0]        dsum;
  logic signed [NW-1:0] n_re;
  logic signed [NW-1:0] n_im;
  logic [NW-1:0]        mag_re;
  logic [NW-1:0]        mag_im;

  always_comb begin
    pp   = '0;
    s_re = '0;
    s_im = '0;

    // Divide numerators and divisor.
    dsum   = NW'(pr.d_rr) + NW'(pr.d_ii);
    n_re   = NW'(pr.p_rr) + NW'(pr.p_ii);
    n_im   = NW'(pr.p_ir) - NW'(pr.p_ri);
    mag_re = n_re[NW-1] ? NW'(-n_re) : NW'(n_re);
    mag_im = n_im[NW-1] ? NW'(-n_im) : NW'(n_im);

    pp.cmd    = pr.cmd;
    pp.neg_re = n_re[NW-1];
    pp.neg_im = n_im[NW-1];
    pp.rem_re = (RW'(mag_re) << (FRAC_BITS + 1)) + RW'(dsum);
    pp.rem_im = (RW'(mag_im) << (FRAC_BITS + 1)) + RW'(dsum);
    pp.den    = DW'(dsum) << 1;

    // CORDIC start vector with guard bits.
    pp.cx = CW'(pr.x0) <<< CORDIC_GUARD;
    pp.cy = CW'(pr.y0) <<< CORDIC_GUARD;
    pp.cz = pr.z0;
    pp.az = pr.az;

    // Results that are complete at this point.
    case (pr.cmd)
      CMD_ADD, CMD_SUB: begin
        s_re = sat_w(SW'(pr.as_re));
        s_im = sat_w(SW'(pr.as_im));
      end
      CMD_MUL: begin
        s_re = sat_w((SW'(pr.p_rr) - SW'(pr.p_ii) + RND_HALF) >>> FRAC_BITS);
        s_im = sat_w((SW'(pr.p_ri) + SW'(pr.p_ir) + RND_HALF) >>> FRAC_BITS);
      end
      CMD_MAG: begin
        s_re = sat_w((SW'(pr.p_rr) + SW'(pr.p_ii) + RND_HALF) >>> FRAC_BITS);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase

    pp.re = s_re.val;
    pp.im = s_im.val;
    pp.st = (s_re.flag || s_im.flag) ? ST_SAT : ST_OK;
    if ((pr.cmd == CMD_DIV) && (dsum == '0)) begin
      pp.st = ST_DIVZ;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cau_step.sv
// ----------------------------------------------------------------------------
// Step stage
// One restoring divide step on both quotients and, for idx below
// ANGLE_ITERATIONS, a CORDIC vectoring step; idx selects the shift amounts.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_step (
  input  cau_pkg::pipe_t            pi,
  input  logic [cau_pkg::STEP_W-1:0] idx,
  output cau_pkg::pipe_t            po
);
  import cau_pkg::*;

  logic [STEP_W-1:0]    k;
  logic [RW-1:0]        dsh;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    po  = pi;
    k   = STEP_W'(NSTEP - 1) - idx;
    dsh = RW'(pi.den) << k;
    dx  = pi.cy >>> idx;
    dy  = pi.cx >>> idx;

    // Restoring divide: one quotient bit per stage, top bit first.
    if (idx >= STEP_W'(NSTEP - QW)) begin
      if (pi.rem_re >= dsh) begin
        po.rem_re         = pi.rem_re - dsh;
        po.q_re[k[QB-1:0]] = 1'b1;
      end
      if (pi.rem_im >= dsh) begin
        po.rem_im         = pi.rem_im - dsh;
        po.q_im[k[QB-1:0]] = 1'b1;
      end
    end

    // CORDIC vectoring: drive y toward zero and accumulate the angle.
    if (idx < STEP_W'(ANGLE_ITERATIONS)) begin
      if (!pi.cy[CW-1]) begin
        po.cx = pi.cx + dx;
        po.cy = pi.cy - dy;
        po.cz = pi.cz + ATAN_TAB[idx];
      end else begin
        po.cx = pi.cx - dx;
        po.cy = pi.cy + dy;
        po.cz = pi.cz - ATAN_TAB[idx];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cau_final.sv
// ----------------------------------------------------------------------------
// Result stage
// Signs and saturates the quotients, rounds and clamps the angle, and picks
// the result word for the command.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_final (
  input  cau_pkg::pipe_t                      pi,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im,
  output logic [1:0]                          status
);
  import cau_pkg::*;

  logic signed [QW:0]   sq_re;
  logic signed [QW:0]   sq_im;
  sat_t                 d_re;
  sat_t                 d_im;
  logic signed [ZW-1:0] zr;

  always_comb begin
    // Signed quotients, then clamp.
    sq_re = pi.neg_re ? -$signed({1'b0, pi.q_re}) : $signed({1'b0, pi.q_re});
    sq_im = pi.neg_im ? -$signed({1'b0, pi.q_im}) : $signed({1'b0, pi.q_im});
    d_re  = sat_w(SW'(sq_re));
    d_im  = sat_w(SW'(sq_im));

    // Angle rounded to 1/128 degree and held to a half turn.
    zr = (pi.cz + ARG_RND) >>> ARG_SHIFT;
    if (zr > HALF_TURN) begin
      zr = HALF_TURN;
    end else if (zr < -HALF_TURN) begin
      zr = -HALF_TURN;
    end

    case (pi.cmd)
      CMD_DIV: begin
        if (pi.st == ST_DIVZ) begin
          res_re = '0;
          res_im = '0;
          status = ST_DIVZ;
        end else begin
          res_re = d_re.val;
          res_im = d_im.val;
          status = (d_re.flag || d_im.flag) ? ST_SAT : ST_OK;
        end
      end
      CMD_ARG: begin
        res_re = pi.az ? '0 : zr[DATA_WIDTH-1:0];
        res_im = '0;
        status = ST_OK;
      end
      default: begin
        res_re = pi.re;
        res_im = pi.im;
        status = pi.st;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/complex_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit result checker
// Watches both channels, computes the expected result of every accepted input
// word and compares each accepted result word against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module complex_arithmetic_unit_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [2:0]                            in_cmd,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_re,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] out_res_im,
  input  logic [1:0]                            out_status,
  output int                                    fail_count,
  output int                                    pending_count
);
  import cau_pkg::*;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic [1:0]                   st;
  } result_t;

  result_t expected_results[$];

  // Floor shift of a signed value.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Clamp to the data range, raising the clamp flag.
  function automatic longint clamp(longint v, ref bit flag);
    longint hi, lo;
    hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint round_q(longint v);
    return floor_shift(v + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
  endfunction

  // Quotient rounded half away from zero.
  function automatic longint quotient(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag <<< (FRAC_BITS + 1)) + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  // Vectoring CORDIC angle in 1/128 degree.
  function automatic longint angle_of(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    x = x <<< CORDIC_GUARD;
    y = y <<< CORDIC_GUARD;
    for (int i = 0; i < ANGLE_ITERATIONS && i < ATAN_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    z = floor_shift(z + 256, 9);
    if (z > 23040) z = 23040;
    if (z < -23040) z = -23040;
    return z;
  endfunction

  function automatic result_t compute_result(logic [2:0] cmd, longint ar, longint ai,
                                             longint br, longint bi);
    result_t r;
    longint re, im, d;
    bit flag;
    re = 0; im = 0; flag = 1'b0;
    r.st = ST_OK;
    case (cmd)
      CMD_ADD: begin
        re = clamp(ar + br, flag); im = clamp(ai + bi, flag);
      end
      CMD_SUB: begin
        re = clamp(ar - br, flag); im = clamp(ai - bi, flag);
      end
      CMD_MUL: begin
        re = clamp(round_q(ar * br - ai * bi), flag);
        im = clamp(round_q(ar * bi + ai * br), flag);
      end
      CMD_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) r.st = ST_DIVZ;
        else begin
          re = clamp(quotient(ar * br + ai * bi, d), flag);
          im = clamp(quotient(ai * br - ar * bi, d), flag);
        end
      end
      CMD_MAG: re = clamp(round_q(ar * ar + ai * ai), flag);
      CMD_ARG: re = angle_of(ar, ai);
      default: ;
    endcase
    if (flag && r.st == ST_OK) r.st = ST_SAT;
    r.re = re[DATA_WIDTH-1:0];
    r.im = im[DATA_WIDTH-1:0];
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Record expectations and compare results at each edge.
  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(compute_result(in_cmd, in_a_re, in_a_im,
                                                  in_b_re, in_b_im));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation waiting");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_res_re !== want.re) begin
            $error("res_re expected %0d actual %0d", want.re, out_res_re);
            errs++;
          end
          if (out_res_im !== want.im) begin
            $error("res_im expected %0d actual %0d", want.im, out_res_im);
            errs++;
          end
          if (out_status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, out_status);
            errs++;
          end
        end
      end
      if (errs != 0)
        fail_count <= fail_count + errs;
    end
  end

endmodule

`default_nettype wire

FILE: sim/complex_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner words and then random words with random idling on
// both channels; a checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int RANDOM_WORDS = 1430;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic signed [DATA_WIDTH-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;
  int fail_count, pending_count;
  bit calm_phase = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_arithmetic_unit dut (.*);

  complex_arithmetic_unit_checker checker_i (.*);

  // Send one word, holding it until the block takes it.
  task automatic send_word(logic [2:0] cmd, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_a_re  <= ar;
    in_a_im  <= ai;
    in_b_re  <= br;
    in_b_im  <= bi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Optional idle burst between words on the input side.
  task automatic maybe_idle();
    int n;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random operand: extremes, small values or anything.
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when asked.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [2:0] cmd;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: every command at the extremes, zero divisor, origin.
    send_word(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_word(CMD_ADD, 16'h0100, 16'hff00, 16'h0001, 16'hffff);
    send_word(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_word(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_word(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_MUL, 16'h0180, 16'h0080, 16'h0080, 16'hff80);
    send_word(CMD_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
    send_word(CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_word(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_word(CMD_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    send_word(CMD_DIV, 16'hff00, 16'h0080, 16'h8000, 16'h7fff);
    send_word(CMD_MAG, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
    send_word(CMD_MAG, 16'h0080, 16'hff80, 16'h0000, 16'h0000);
    send_word(CMD_ARG, 16'h0000, 16'h0000, 16'h1234, 16'h5678);
    send_word(CMD_ARG, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_ARG, 16'h8000, 16'hffff, 16'h0000, 16'h0000);
    send_word(CMD_ARG, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_word(CMD_ARG, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
    send_word(CMD_ARG, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_word(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    in_valid <= 1'b0;

    // Pause until every expected result has come.
    wait (pending_count == 0);
    @(posedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 200) hold_off_req = 1'b1;
      if (i == RANDOM_WORDS - 250) calm_phase = 1'b1;
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      if (cmd == CMD_DIV && $urandom_range(0, 9) == 0)
        send_word(cmd, rand_operand(), rand_operand(), 16'h0000, 16'h0000);
      else
        send_word(cmd, rand_operand(), rand_operand(), rand_operand(), rand_operand());
      maybe_idle();
    end
    in_valid <= 1'b0;

    wait (pending_count == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hdl/cau_pkg.sv
hdl/cau_mult.sv
hdl/cau_init.sv
hdl/cau_step.sv
hdl/cau_final.sv
hdl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_checker.sv
sim/complex_arithmetic_unit_tb.sv
